// ----- hw/rtl/lts_pkg.sv -----
// Shared types, codes and character helpers for the lexer token scanner.
`timescale 1ns / 1ps
`default_nettype none
package lts_pkg;

  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;

  localparam int KIND_W = 5;
  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam int LEN_W  = 16;
  localparam int MANT_W = 32;
  localparam int FRAC_W = 5;

  // token queue depth: room for a two-word push on top of two waiting words
  localparam int QDEPTH = 4;

  localparam logic [KIND_W-1:0] K_EOF     = 5'd0;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd1;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd2;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd3;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd4;
  localparam logic [KIND_W-1:0] K_LBRACK  = 5'd5;
  localparam logic [KIND_W-1:0] K_RBRACK  = 5'd6;
  localparam logic [KIND_W-1:0] K_COMMA   = 5'd7;
  localparam logic [KIND_W-1:0] K_COLON   = 5'd8;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd9;
  localparam logic [KIND_W-1:0] K_DOT     = 5'd10;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd11;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd12;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd13;
  localparam logic [KIND_W-1:0] K_SLASH   = 5'd14;
  localparam logic [KIND_W-1:0] K_STRING  = 5'd15;
  localparam logic [KIND_W-1:0] K_COMMENT = 5'd16;
  localparam logic [KIND_W-1:0] K_EOL     = 5'd17;
  localparam logic [KIND_W-1:0] K_SPACING = 5'd18;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd19;
  localparam logic [KIND_W-1:0] K_NUMBER  = 5'd20;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd21;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd31;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SLASH,
    M_LINECOM,
    M_BLOCK,
    M_STR_DQ,
    M_STR_SQ,
    M_EOL,
    M_SPACE,
    M_IDENT,
    M_NUM_INT,
    M_NUM_FRAC
  } mode_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [LEN_W-1:0]  len;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    logic              last;
  } tok_t;

  // tokens caused by one byte, oldest in t0
  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_COMMA:  k = K_COMMA;
      CH_COLON:  k = K_COLON;
      CH_SEMI:   k = K_SEMI;
      CH_DOT:    k = K_DOT;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      default:   k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // m*10 + digit as shifts and adds, saturating at all ones
  function automatic logic [MANT_W-1:0] add_digit(input logic [MANT_W-1:0] m,
                                                  input logic [7:0] c);
    logic [MANT_W+3:0] t;
    t = ((MANT_W+4)'(m) << 3) + ((MANT_W+4)'(m) << 1) + (MANT_W+4)'(c - CH_0);
    return (t[MANT_W+3:MANT_W] != '0) ? '1 : t[MANT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lts_scan.sv -----
// Scanner state and per-byte token decode.
`timescale 1ns / 1ps
`default_nettype none
module lts_scan #(
  parameter int LINE_BITS   = lts_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire logic [7:0]    char_code,
  output lts_pkg::push_t     push
);
  import lts_pkg::*;

  localparam int LXW = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
  localparam int CXW = (COLUMN_BITS > COL_W) ? COLUMN_BITS : COL_W;

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] col_inc(input logic [COLUMN_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_W-1:0] line_out(input logic [LINE_BITS-1:0] v);
    logic [LXW-1:0] e;
    e = LXW'(v);
    return e[LINE_W-1:0];
  endfunction

  function automatic logic [COL_W-1:0] col_out(input logic [COLUMN_BITS-1:0] v);
    logic [CXW-1:0] e;
    e = CXW'(v);
    return e[COL_W-1:0];
  endfunction

  mode_t                  mode_r, mode_s, mode_nxt;
  logic [KIND_W-1:0]      kind_r, kind_s, kind_nxt;
  logic [LINE_W-1:0]      pline_r, pline_s, pline_nxt;
  logic [COL_W-1:0]       pcol_r, pcol_s, pcol_nxt;
  logic [LEN_W-1:0]       plen_r, plen_s, plen_nxt;
  logic [LINE_BITS-1:0]   line_r, line_s, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_s, col_nxt;
  logic [MANT_W-1:0]      mant_r, mant_s, mant_nxt;
  logic [FRAC_W-1:0]      frac_r, frac_s, frac_nxt;
  logic                   esc_r, esc_s, esc_nxt;
  logic                   star_r, star_s, star_nxt;
  logic [7:0]             feol_r, feol_s, feol_nxt;
  logic                   pend_emit, restart;
  logic [7:0]             c;

  assign c = char_code;

  // Continue the open token or close it; unless this byte ends it, ask for a fresh start.
  always_comb begin
    mode_s    = mode_r;
    kind_s    = kind_r;
    pline_s   = pline_r;
    pcol_s    = pcol_r;
    plen_s    = plen_r;
    line_s    = line_r;
    col_s     = col_r;
    mant_s    = mant_r;
    frac_s    = frac_r;
    esc_s     = esc_r;
    star_s    = star_r;
    feol_s    = feol_r;
    pend_emit = 1'b0;
    restart   = 1'b0;
    unique case (mode_r)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          kind_s = K_COMMENT;
          mode_s = M_LINECOM;
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else if (c == CH_STAR) begin
          kind_s = K_COMMENT;
          mode_s = M_BLOCK;
          star_s = 1'b0;
          feol_s = CH_NUL;
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end
      end
      M_LINECOM: begin
        if (c != CH_NUL && !is_eol(c)) begin
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end
      end
      M_BLOCK: begin
        if (c == CH_NUL) begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end else begin
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
          if (star_r && c == CH_SLASH) begin
            pend_emit = 1'b1;
          end else begin
            star_s = (c == CH_STAR);
            if (is_eol(c)) begin
              // second byte of a CR/LF or LF/CR pair counts no new line
              if (feol_r != CH_NUL && c != feol_r) begin
                feol_s = CH_NUL;
              end else begin
                line_s = line_inc(line_r);
                feol_s = c;
              end
            end else begin
              feol_s = CH_NUL;
            end
          end
        end
      end
      M_STR_DQ, M_STR_SQ: begin
        if (c == CH_NUL) begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end else begin
          col_s = col_inc(col_r);
          if (esc_r) begin
            esc_s  = 1'b0;
            plen_s = len_inc(plen_r);
          end else if (c == ((mode_r == M_STR_DQ) ? CH_DQ : CH_SQ)) begin
            pend_emit = 1'b1;
          end else begin
            if (c == CH_BSLASH) esc_s = 1'b1;
            plen_s = len_inc(plen_r);
          end
        end
      end
      M_EOL: begin
        feol_s    = CH_NUL;
        pend_emit = 1'b1;
        if (is_eol(c) && c != feol_r) begin
          plen_s = len_inc(plen_r);
        end else begin
          restart = 1'b1;
        end
      end
      M_SPACE: begin
        if (is_space(c)) begin
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == CH_US) begin
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end
      end
      M_NUM_INT, M_NUM_FRAC: begin
        if (is_digit(c)) begin
          if (mode_r == M_NUM_INT) begin
            mant_s = add_digit(mant_r, c);
          end else if (frac_r < FRAC_MAX) begin
            mant_s = add_digit(mant_r, c);
            frac_s = frac_r + 1'b1;
          end
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else if (c == CH_DOT && mode_r == M_NUM_INT) begin
          mode_s = M_NUM_FRAC;
          plen_s = len_inc(plen_r);
          col_s  = col_inc(col_r);
        end else if (c == CH_LC_F) begin
          plen_s    = len_inc(plen_r);
          col_s     = col_inc(col_r);
          pend_emit = 1'b1;
        end else begin
          pend_emit = 1'b1;
          restart   = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase
  end

  // Emit the closed token, then, on a fresh start, begin a new one from this byte.
  always_comb begin
    tok_t ptok;
    tok_t btok;
    logic bemit;
    mode_nxt  = pend_emit ? M_IDLE : mode_s;
    kind_nxt  = kind_s;
    pline_nxt = pline_s;
    pcol_nxt  = pcol_s;
    plen_nxt  = plen_s;
    line_nxt  = line_s;
    col_nxt   = col_s;
    mant_nxt  = mant_s;
    frac_nxt  = frac_s;
    esc_nxt   = esc_s;
    star_nxt  = star_s;
    feol_nxt  = feol_s;
    push      = '0;
    bemit     = 1'b0;

    ptok      = '0;
    ptok.kind = kind_s;
    ptok.line = pline_s;
    ptok.col  = pcol_s;
    ptok.len  = plen_s;
    ptok.mant = (kind_s == K_NUMBER) ? mant_s : '0;
    ptok.frac = (kind_s == K_NUMBER) ? frac_s : '0;
    if (pend_emit) begin
      push.t0 = ptok;
      push.n  = 2'd1;
    end

    btok      = '0;
    btok.line = line_out(line_s);
    btok.col  = col_out(col_s);
    btok.len  = LEN_W'(1);
    if (restart) begin
      pline_nxt = line_out(line_s);
      pcol_nxt  = col_out(col_s);
      plen_nxt  = LEN_W'(1);
      mant_nxt  = '0;
      frac_nxt  = '0;
      esc_nxt   = 1'b0;
      star_nxt  = 1'b0;
      feol_nxt  = CH_NUL;
      mode_nxt  = M_IDLE;
      priority if (c == CH_NUL) begin
        btok.kind = K_EOF;
        btok.len  = '0;
        bemit     = 1'b1;
        kind_nxt  = K_EOF;
        pline_nxt = '0;
        pcol_nxt  = '0;
        plen_nxt  = '0;
        line_nxt  = '0;
        col_nxt   = '0;
      end else if (punct_kind(c) != K_EOF) begin
        btok.kind = punct_kind(c);
        bemit     = 1'b1;
        col_nxt   = col_inc(col_s);
      end else if (c == CH_SLASH) begin
        kind_nxt = K_SLASH;
        mode_nxt = M_SLASH;
        col_nxt  = col_inc(col_s);
      end else if (c == CH_DQ || c == CH_SQ) begin
        kind_nxt = K_STRING;
        plen_nxt = '0;
        mode_nxt = (c == CH_DQ) ? M_STR_DQ : M_STR_SQ;
        col_nxt  = col_inc(col_s);
      end else if (is_eol(c)) begin
        kind_nxt = K_EOL;
        mode_nxt = M_EOL;
        feol_nxt = c;
        line_nxt = line_inc(line_s);
        col_nxt  = '0;
      end else if (is_space(c)) begin
        kind_nxt = K_SPACING;
        mode_nxt = M_SPACE;
        col_nxt  = col_inc(col_s);
      end else if (is_letter(c)) begin
        kind_nxt = K_IDENT;
        mode_nxt = M_IDENT;
        col_nxt  = col_inc(col_s);
      end else if (is_digit(c)) begin
        kind_nxt = K_NUMBER;
        mode_nxt = M_NUM_INT;
        mant_nxt = add_digit('0, c);
        col_nxt  = col_inc(col_s);
      end else begin
        btok.kind = K_UNKNOWN;
        bemit     = 1'b1;
        col_nxt   = col_inc(col_s);
      end
    end

    if (bemit) begin
      if (push.n == 2'd0) begin
        push.t0 = btok;
        push.n  = 2'd1;
      end else begin
        push.t1 = btok;
        push.n  = 2'd2;
      end
    end

    if (push.n == 2'd2) begin
      push.t1.last = 1'b1;
    end else if (push.n == 2'd1) begin
      push.t0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      kind_r  <= K_EOF;
      pline_r <= '0;
      pcol_r  <= '0;
      plen_r  <= '0;
      line_r  <= '0;
      col_r   <= '0;
      mant_r  <= '0;
      frac_r  <= '0;
      esc_r   <= 1'b0;
      star_r  <= 1'b0;
      feol_r  <= CH_NUL;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      kind_r  <= kind_nxt;
      pline_r <= pline_nxt;
      pcol_r  <= pcol_nxt;
      plen_r  <= plen_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      mant_r  <= mant_nxt;
      frac_r  <= frac_nxt;
      esc_r   <= esc_nxt;
      star_r  <= star_nxt;
      feol_r  <= feol_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lts_queue.sv -----
// Small token queue: takes up to two tokens a cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none
module lts_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_en,
  input  lts_pkg::push_t     push,
  input  wire logic          pop,
  output lts_pkg::tok_t      head,
  output logic               not_empty,
  output logic               room2
);
  import lts_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  tok_t          mem [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    npush;

  assign npush     = push_en ? push.n : 2'd0;
  assign head      = mem[rp_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= CW'(QDEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + PW'(npush);
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + CW'(npush) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) mem[wp_r] <= push.t0;
    if (npush == 2'd2) mem[wp_r + 1'b1] <= push.t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/lexer_token_scanner_top.sv -----
// Lexer token scanner top level: input register, scanner and token queue.
// A taken byte waits in the input register; its tokens then go into the queue.
// Throughput: one byte per cycle while the consumer keeps up; a byte that closes
// one token and is a one-byte token pushes two words; the queue drains one a cycle.
// The input register holds while the four-entry token queue lacks room for two.
// Reset (rst_n low, synchronous) clears the scanner to line 0, column 0 and
// empties the queue; a zero byte also returns the scanner to that state.
`timescale 1ns / 1ps
`default_nettype none
module lexer_token_scanner_top #(
  parameter int LINE_BITS   = lts_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_char_code,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lts_pkg::KIND_W-1:0]       out_token_kind,
  output logic [lts_pkg::LINE_W-1:0]       out_start_line,
  output logic [lts_pkg::COL_W-1:0]        out_start_column,
  output logic [lts_pkg::LEN_W-1:0]        out_token_length,
  output logic [lts_pkg::MANT_W-1:0]       out_number_mantissa,
  output logic [lts_pkg::FRAC_W-1:0]       out_fraction_digits,
  output logic                             out_last
);
  import lts_pkg::*;

  logic       hold_r, hold_nxt;
  logic [7:0] byte_r;
  logic       advance, room2, in_take, pop;
  push_t      push;
  tok_t       head;

  // Advance the held byte into the scanner only when both of its tokens fit.
  assign advance  = hold_r && room2;
  assign in_stall = hold_r && !room2;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    hold_nxt = hold_r;
    if (in_take) begin
      hold_nxt = 1'b1;
    end else if (advance) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  // Payload needs no reset; hold it while the stage is stalled.
  always_ff @(posedge clk) begin
    if (in_take) byte_r <= in_char_code;
  end

  lts_scan #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .char_code (byte_r),
    .push      (push)
  );

  // Drop a word from the queue when the consumer takes it.
  assign pop = out_valid && !out_stall;

  lts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (advance),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign out_token_kind      = head.kind;
  assign out_start_line      = head.line;
  assign out_start_column    = head.col;
  assign out_token_length    = head.len;
  assign out_number_mantissa = head.mant;
  assign out_fraction_digits = head.frac;
  assign out_last            = head.last;

endmodule
`default_nettype wire

// ----- dv/lts_token_checker.sv -----
// Token checker for the lexer token scanner: predicts tokens from accepted bytes and compares.
`timescale 1ns / 1ps
module lts_token_checker #(
  parameter int LINE_BITS   = lts_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = lts_pkg::COLUMN_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_char_code,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [lts_pkg::KIND_W-1:0]  out_token_kind,
  input  logic [lts_pkg::LINE_W-1:0]  out_start_line,
  input  logic [lts_pkg::COL_W-1:0]   out_start_column,
  input  logic [lts_pkg::LEN_W-1:0]   out_token_length,
  input  logic [lts_pkg::MANT_W-1:0]  out_number_mantissa,
  input  logic [lts_pkg::FRAC_W-1:0]  out_fraction_digits,
  input  logic                        out_last,
  output int                          mismatch_count,
  output int                          tokens_waiting,
  output int                          tokens_checked,
  output logic [21:0]                 kinds_seen
);
  import lts_pkg::*;

  localparam logic [63:0] LINE_TOP = (64'd1 << LINE_BITS) - 64'd1;
  localparam logic [63:0] COL_TOP  = (64'd1 << COLUMN_BITS) - 64'd1;

  // scanner state as the predictor sees it
  mode_t             mode;
  logic [KIND_W-1:0] open_kind;
  logic [31:0]       open_line;
  logic [31:0]       open_col;
  logic [LEN_W-1:0]  open_len;
  logic [31:0]       cur_line;
  logic [31:0]       cur_col;
  logic [MANT_W-1:0] mant;
  logic [FRAC_W-1:0] frac_cnt;
  logic              in_escape;
  logic              after_star;
  logic [7:0]        break_byte;

  tok_t        byte_toks [0:1];
  int          byte_tok_n;
  tok_t        lexed_tokens [$];
  int          errors;
  int          checked;
  logic [21:0] kinds;

  function automatic logic is_break(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [KIND_W-1:0] one_byte_kind(input logic [7:0] c);
    case (c)
      CH_LBRACE: return K_LBRACE;
      CH_RBRACE: return K_RBRACE;
      CH_LPAREN: return K_LPAREN;
      CH_RPAREN: return K_RPAREN;
      CH_LBRACK: return K_LBRACK;
      CH_RBRACK: return K_RBRACK;
      CH_COMMA:  return K_COMMA;
      CH_COLON:  return K_COLON;
      CH_SEMI:   return K_SEMI;
      CH_DOT:    return K_DOT;
      CH_PLUS:   return K_PLUS;
      CH_MINUS:  return K_MINUS;
      CH_STAR:   return K_STAR;
      default:   return K_EOF;
    endcase
  endfunction

  task automatic clear_scan();
    mode       = M_IDLE;
    open_kind  = K_EOF;
    open_line  = '0;
    open_col   = '0;
    open_len   = '0;
    cur_line   = '0;
    cur_col    = '0;
    mant       = '0;
    frac_cnt   = '0;
    in_escape  = 1'b0;
    after_star = 1'b0;
    break_byte = CH_NUL;
  endtask

  task automatic col_step();
    if (cur_col < COL_TOP) cur_col++;
  endtask

  task automatic line_step();
    if (cur_line < LINE_TOP) cur_line++;
  endtask

  task automatic len_step();
    if (open_len != '1) open_len++;
  endtask

  task automatic digit_in(input logic [7:0] c);
    logic [63:0] t;
    t = {32'd0, mant} * 64'd10 + 64'(c - CH_0);
    mant = (t > 64'hFFFF_FFFF) ? '1 : t[31:0];
  endtask

  task automatic emit(input logic [KIND_W-1:0] k, input logic [31:0] ln, input logic [31:0] cl,
                      input logic [LEN_W-1:0] n, input logic [MANT_W-1:0] m,
                      input logic [FRAC_W-1:0] f);
    if (byte_tok_n < 2) begin
      byte_toks[byte_tok_n] = {k, ln[LINE_W-1:0], cl[COL_W-1:0], n, m, f, 1'b0};
      byte_tok_n++;
    end
  endtask

  // close the token in progress; only numbers carry a value
  task automatic close_open();
    if (open_kind == K_NUMBER) emit(open_kind, open_line, open_col, open_len, mant, frac_cnt);
    else emit(open_kind, open_line, open_col, open_len, '0, '0);
    mode = M_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    k          = one_byte_kind(c);
    open_line  = cur_line;
    open_col   = cur_col;
    open_len   = 16'd1;
    mant       = '0;
    frac_cnt   = '0;
    in_escape  = 1'b0;
    after_star = 1'b0;
    break_byte = CH_NUL;
    mode       = M_IDLE;
    if (c == CH_NUL) begin
      emit(K_EOF, cur_line, cur_col, '0, '0, '0);
      clear_scan();
    end else if (k != K_EOF) begin
      emit(k, cur_line, cur_col, 16'd1, '0, '0);
      col_step();
    end else if (c == CH_SLASH) begin
      open_kind = K_SLASH;
      mode      = M_SLASH;
      col_step();
    end else if ((c == CH_DQ) || (c == CH_SQ)) begin
      open_kind = K_STRING;
      open_len  = '0;
      mode      = (c == CH_DQ) ? M_STR_DQ : M_STR_SQ;
      col_step();
    end else if (is_break(c)) begin
      open_kind  = K_EOL;
      mode       = M_EOL;
      break_byte = c;
      line_step();
      cur_col = '0;
    end else if (is_blank(c)) begin
      open_kind = K_SPACING;
      mode      = M_SPACE;
      col_step();
    end else if (is_alpha(c)) begin
      open_kind = K_IDENT;
      mode      = M_IDENT;
      col_step();
    end else if (is_num(c)) begin
      open_kind = K_NUMBER;
      mode      = M_NUM_INT;
      digit_in(c);
      col_step();
    end else begin
      emit(K_UNKNOWN, cur_line, cur_col, 16'd1, '0, '0);
      col_step();
    end
  endtask

  // advance the prediction by one byte and queue the tokens it causes
  task automatic scan_byte(input logic [7:0] c);
    logic restart;
    restart    = 1'b0;
    byte_tok_n = 0;
    case (mode)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          open_kind = K_COMMENT;
          mode      = M_LINECOM;
          len_step();
          col_step();
        end else if (c == CH_STAR) begin
          open_kind  = K_COMMENT;
          mode       = M_BLOCK;
          after_star = 1'b0;
          break_byte = CH_NUL;
          len_step();
          col_step();
        end else begin
          close_open();
          restart = 1'b1;
        end
      end
      M_LINECOM: begin
        if ((c != CH_NUL) && !is_break(c)) begin
          len_step();
          col_step();
        end else begin
          close_open();
          restart = 1'b1;
        end
      end
      M_BLOCK: begin
        if (c == CH_NUL) begin
          close_open();
          restart = 1'b1;
        end else begin
          len_step();
          col_step();
          if (after_star && (c == CH_SLASH)) begin
            close_open();
          end else begin
            after_star = (c == CH_STAR);
            // a CR/LF or LF/CR pair counts as one line break
            if (is_break(c)) begin
              if ((break_byte != CH_NUL) && (c != break_byte)) begin
                break_byte = CH_NUL;
              end else begin
                line_step();
                break_byte = c;
              end
            end else begin
              break_byte = CH_NUL;
            end
          end
        end
      end
      M_STR_DQ, M_STR_SQ: begin
        if (c == CH_NUL) begin
          close_open();
          restart = 1'b1;
        end else begin
          col_step();
          if (in_escape) begin
            in_escape = 1'b0;
            len_step();
          end else if (c == ((mode == M_STR_DQ) ? CH_DQ : CH_SQ)) begin
            close_open();
          end else begin
            if (c == CH_BSLASH) in_escape = 1'b1;
            len_step();
          end
        end
      end
      M_EOL: begin
        if (is_break(c) && (c != break_byte)) begin
          len_step();
          break_byte = CH_NUL;
          close_open();
        end else begin
          break_byte = CH_NUL;
          close_open();
          restart = 1'b1;
        end
      end
      M_SPACE: begin
        if (is_blank(c)) begin
          len_step();
          col_step();
        end else begin
          close_open();
          restart = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_num(c) || (c == CH_US)) begin
          len_step();
          col_step();
        end else begin
          close_open();
          restart = 1'b1;
        end
      end
      M_NUM_INT, M_NUM_FRAC: begin
        if (is_num(c)) begin
          if (mode == M_NUM_INT) begin
            digit_in(c);
          end else if (frac_cnt < FRAC_MAX) begin
            digit_in(c);
            frac_cnt++;
          end
          len_step();
          col_step();
        end else if ((c == CH_DOT) && (mode == M_NUM_INT)) begin
          mode = M_NUM_FRAC;
          len_step();
          col_step();
        end else if (c == CH_LC_F) begin
          len_step();
          col_step();
          close_open();
        end else begin
          close_open();
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase
    if (restart) open_token(c);
    for (int i = 0; i < byte_tok_n; i++) begin
      if (i == byte_tok_n - 1) byte_toks[i].last = 1'b1;
      lexed_tokens.push_back(byte_toks[i]);
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] token check: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s is %0d, predicted %0d", checked, name, got, want));
    end
  endtask

  task automatic compare_token(input tok_t got);
    tok_t want;
    if (got.kind < 5'd22) kinds[got.kind] = 1'b1;
    if (lexed_tokens.size() == 0) begin
      report_mismatch($sformatf("token %0d (kind %0d) with nothing predicted", checked, got.kind));
    end else begin
      want = lexed_tokens.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("start line", got.line, want.line);
      check_field("start column", got.col, want.col);
      check_field("length", got.len, want.len);
      check_field("mantissa", got.mant, want.mant);
      check_field("fraction digits", got.frac, want.frac);
      check_field("last flag", got.last, want.last);
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      lexed_tokens.delete();
      errors  = 0;
      checked = 0;
      kinds   = '0;
    end else begin
      if (in_valid && !in_stall) scan_byte(in_char_code);
      if (out_valid && !out_stall) begin
        compare_token({out_token_kind, out_start_line, out_start_column, out_token_length,
                       out_number_mantissa, out_fraction_digits, out_last});
      end
    end
    mismatch_count <= errors;
    tokens_waiting <= lexed_tokens.size();
    tokens_checked <= checked;
    kinds_seen     <= kinds;
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the lexer token scanner: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import lts_pkg::*;

  // random part stops once this many bytes have gone in altogether
  localparam int TOTAL_BYTES     = 1250;
  // one long output hold-off so the token queue fills and the input stalls
  localparam int HOLD_OFF_CYCLES = 300;
  // quiet spell once every predicted token is checked; margin for strays
  localparam int DRAIN_CYCLES    = 20;
  // watchdog time in ns; set well above the slowest correct run
  localparam longint TIMEOUT_NS  = 64'd10_000_000;

  logic clk          = 1'b0;
  logic rst_n        = 1'b0;
  logic in_valid     = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic out_stall    = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [KIND_W-1:0] out_token_kind;
  logic [LINE_W-1:0] out_start_line;
  logic [COL_W-1:0]  out_start_column;
  logic [LEN_W-1:0]  out_token_length;
  logic [MANT_W-1:0] out_number_mantissa;
  logic [FRAC_W-1:0] out_fraction_digits;
  logic              out_last;

  int          mismatch_count;
  int          tokens_waiting;
  int          tokens_checked;
  logic [21:0] kinds_seen;

  // idle knobs, changed per stretch of stimulus (percent chance of a pause)
  int   tx_idle_pct    = 0;
  int   rx_stall_pct   = 0;
  logic hold_off_req   = 1'b0;
  int   bytes_fed      = 0;
  int   stalled_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lexer_token_scanner_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_code        (in_char_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_start_line      (out_start_line),
    .out_start_column    (out_start_column),
    .out_token_length    (out_token_length),
    .out_number_mantissa (out_number_mantissa),
    .out_fraction_digits (out_fraction_digits),
    .out_last            (out_last)
  );

  lts_token_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_char_code        (in_char_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_token_kind      (out_token_kind),
    .out_start_line      (out_start_line),
    .out_start_column    (out_start_column),
    .out_token_length    (out_token_length),
    .out_number_mantissa (out_number_mantissa),
    .out_fraction_digits (out_fraction_digits),
    .out_last            (out_last),
    .mismatch_count      (mismatch_count),
    .tokens_waiting      (tokens_waiting),
    .tokens_checked      (tokens_checked),
    .kinds_seen          (kinds_seen)
  );

  // count cycles where the scanner pushes back on an offered word
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) stalled_cycles <= stalled_cycles + 1;
  end

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // offer one word, maybe after an idle gap, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_fed++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // a run of well-formed tokens with random content, plus some noise
  task automatic send_random_text();
    int         n_tok;
    logic [7:0] q;
    logic [7:0] b;
    n_tok = $urandom_range(1, 24);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(11))
        0: send_byte(pick("{}()[],:;.+-*/"));
        1, 2: begin
          send_byte(pick("abcfqxyzABCQXYZ"));
          repeat ($urandom_range(0, 8)) send_byte(pick("aZf_09xQ"));
        end
        3, 4: begin
          repeat ($urandom_range(1, 12)) send_byte(pick("0123456789"));
          if ($urandom_range(1)) begin
            send_byte(CH_DOT);
            // sometimes run past the fraction digit limit
            repeat (($urandom_range(3) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 5))
              send_byte(pick("0123456789"));
          end
          if ($urandom_range(2) == 0) send_byte(CH_LC_F);
        end
        5: begin
          q = $urandom_range(1) ? CH_DQ : CH_SQ;
          send_byte(q);
          repeat ($urandom_range(0, 8)) begin
            if ($urandom_range(3) == 0) begin
              send_byte(CH_BSLASH);
              send_byte(8'($urandom_range(1, 255)));
            end else begin
              send_byte(pick("ab 9\n\015*/_\"'"));
            end
          end
          if ($urandom_range(9) != 0) send_byte(q);
        end
        6: begin
          send_str("//");
          repeat ($urandom_range(0, 10)) begin
            b = 8'($urandom_range(1, 255));
            send_byte(((b == CH_CR) || (b == CH_LF)) ? CH_SPACE : b);
          end
          send_byte($urandom_range(1) ? CH_LF : CH_CR);
        end
        7: begin
          send_str("/*");
          repeat ($urandom_range(0, 10)) send_byte(pick("ab */\n\015**"));
          send_str("*/");
        end
        8: begin
          case ($urandom_range(3))
            0: send_byte(CH_LF);
            1: send_byte(CH_CR);
            2: send_str("\015\n");
            default: send_str("\n\015");
          endcase
        end
        9: repeat ($urandom_range(1, 4)) send_byte(pick(" \t\v\f"));
        10: send_byte(8'($urandom_range(1, 255)));
        default: send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    // most texts end cleanly; the rest run on into the next one
    if ($urandom_range(9) != 0) send_byte(CH_NUL);
  endtask

  // output side: random stall stretches, plus one long hold-off on request
  initial begin : receiver
    int   span;
    logic hold;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        span = HOLD_OFF_CYCLES;
        hold = 1'b1;
        hold_off_req <= 1'b0;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        span = pause_len();
        hold = 1'b1;
      end else begin
        span = 1;
        hold = 1'b0;
      end
      out_stall <= hold;
      repeat (span) @(posedge clk);
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timed out waiting for the scanner to drain");
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed texts: every kind, pairing of line breaks, escapes, unterminated
    // tokens, number limits and stray bytes
    tx_idle_pct  = 30;
    rx_stall_pct = 30;
    send_str("{}()[],:;.+-*/");
    send_byte(CH_NUL);
    send_str("ab_9 Zz _q 12.5f 3. 7.25 1.f 12f3 1..2 /a\t\v\f \015\n\n\015\015\015");
    send_byte(CH_NUL);
    send_str("\"a\\\"b\\\\\" 'x\\'y\"' \"\015\n\"");
    send_byte(CH_NUL);
    send_str("// note\n/* a*\015\n* b\n\015\015**/x/**/");
    send_byte(CH_NUL);
    // string cut off right after a backslash, then other unterminated tokens
    send_str("\"abc\\");
    send_byte(CH_NUL);
    send_str("'ab");
    send_byte(CH_NUL);
    send_str("/* open\n");
    send_byte(CH_NUL);
    send_str("//tail");
    send_byte(CH_NUL);
    // more fraction digits than the counter holds, then mantissa saturation
    send_str("0.");
    repeat (40) send_byte("9");
    send_str("f 4294967295 4294967296 99999999999.5 ");
    send_byte(CH_NUL);
    send_str("\001\177\200\377_#@\\");
    send_byte(CH_NUL);
    // empty text
    send_byte(CH_NUL);

    // hold the output off while bytes keep coming so the input backs up
    tx_idle_pct = 0;
    hold_off_req <= 1'b1;
    repeat (8) send_random_text();

    // random texts, idling and stalling knobs re-drawn per text
    while (bytes_fed < TOTAL_BYTES) begin
      tx_idle_pct  = 30 * $urandom_range(2);
      rx_stall_pct = 30 * $urandom_range(2);
      send_random_text();
    end
    send_byte(CH_NUL);

    // drop valid, wait for every predicted token, then a short quiet spell
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d source bytes and %0d tokens, %0d of 22 token kinds seen",
             bytes_fed, tokens_checked, $countones(kinds_seen));
    $display("Input was held back for %0d cycles, with one %0d-cycle output hold-off",
             stalled_cycles, HOLD_OFF_CYCLES);
    if ((mismatch_count == 0) && (tokens_waiting == 0)) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
